FILE: sv/tksm_pkg.sv
package tksm_pkg;

  localparam int MaxListLength = 64;
  localparam int AddrW = $clog2(MaxListLength);
  localparam int CntW = $clog2(MaxListLength + 1);
  localparam int IdW = 48;
  localparam int DistW = 32;
  localparam int CfgW = 7;
  localparam int CfgIdxW = 1;
  localparam int EntryW = IdW + 1 + DistW;

  localparam logic REQ_LEFT = 1'b0;
  localparam logic REQ_RIGHT = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_LIST_LENGTH = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_DESCENDING = 1'b1;

  typedef struct packed {
    logic [IdW-1:0] id;
    logic valid;
    logic signed [DistW-1:0] distance;
  } entry_t;

  typedef struct packed {
    logic start;
    logic desc;
    logic [CntW-1:0] k;
  } merge_cmd_t;

  // list length clamped to 1..MaxListLength
  function automatic logic [CntW-1:0] active_len(input logic [CfgW-1:0] len);
    logic [CntW-1:0] k;
    begin
      if (len == '0) begin
        k = CntW'(1);
      end else if (int'(len) > MaxListLength) begin
        k = CntW'(MaxListLength);
      end else begin
        k = CntW'(len);
      end
      return k;
    end
  endfunction

endpackage

FILE: sv/tksm_ram.sv
module tksm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/tksm_merge.sv
module tksm_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  tksm_pkg::merge_cmd_t                cmd,
  input  tksm_pkg::entry_t                    left_q,
  input  tksm_pkg::entry_t                    right_q,
  output logic [tksm_pkg::AddrW-1:0]          left_raddr,
  output logic [tksm_pkg::AddrW-1:0]          right_raddr,
  output logic                                busy,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [tksm_pkg::IdW-1:0]            merged_id,
  output logic                                merged_valid,
  output logic signed [tksm_pkg::DistW-1:0]   merged_distance,
  output logic                                run_last
);

  typedef enum logic [1:0] {M_IDLE, M_FETCH, M_PICK} mstate_t;

  mstate_t state;
  logic [tksm_pkg::CntW-1:0] lit;
  logic [tksm_pkg::CntW-1:0] rit;
  logic [tksm_pkg::CntW-1:0] pos;
  logic [tksm_pkg::CntW-1:0] k;
  logic desc;

  logic take_left;
  logic out_free;
  logic emit;
  logic last_pick;
  tksm_pkg::entry_t pick;

  assign left_raddr = lit[tksm_pkg::AddrW-1:0];
  assign right_raddr = rit[tksm_pkg::AddrW-1:0];
  assign busy = (state != M_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign emit = (state == M_PICK) && out_free;
  assign last_pick = ((pos + tksm_pkg::CntW'(1)) == k);

  // invalid left loses, then invalid right loses, ties go left
  always_comb begin
    if (!left_q.valid) begin
      take_left = 1'b0;
    end else if (!right_q.valid) begin
      take_left = 1'b1;
    end else if (desc) begin
      take_left = ($signed(left_q.distance) >= $signed(right_q.distance));
    end else begin
      take_left = ($signed(left_q.distance) <= $signed(right_q.distance));
    end
    pick = take_left ? left_q : right_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      lit <= '0;
      rit <= '0;
      pos <= '0;
      k <= tksm_pkg::CntW'(1);
      desc <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !emit) begin
        out_valid <= 1'b0;
      end
      case (state)
        M_IDLE: begin
          if (cmd.start) begin
            lit <= '0;
            rit <= '0;
            pos <= '0;
            k <= cmd.k;
            desc <= cmd.desc;
            state <= M_FETCH;
          end
        end
        M_FETCH: begin
          // read data for the current heads shows up next cycle
          state <= M_PICK;
        end
        M_PICK: begin
          if (out_free) begin
            out_valid <= 1'b1;
            merged_id <= pick.id;
            merged_valid <= pick.valid;
            merged_distance <= pick.distance;
            run_last <= last_pick;
            if (take_left) begin
              lit <= lit + tksm_pkg::CntW'(1);
            end else begin
              rit <= rit + tksm_pkg::CntW'(1);
            end
            pos <= pos + tksm_pkg::CntW'(1);
            state <= last_pick ? M_IDLE : M_FETCH;
          end
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_ptr_sum: assert property (@(posedge clk) disable iff (rst)
    (state != M_IDLE) |->
      (({1'b0, lit} + {1'b0, rit}) == {1'b0, pos}))
    else $error("head pointers out of step with output position");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (state == M_PICK) |-> ((lit < k) && (rit < k) && (pos < k)))
    else $error("merge walked past the list length");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> (state == M_IDLE))
    else $error("merge started while busy");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (emit && last_pick) |=> (state == M_IDLE && out_valid && run_last))
    else $error("last beat did not close the run");
`endif

endmodule

FILE: sv/topk_sorted_list_merge.sv
// channel  | handshake             | payload
// ---------+-----------------------+-----------------------------------------------
// in       | in_valid / in_stall   | req_type, entry_id, entry_valid, entry_distance
// out      | out_valid / out_stall | merged_id, merged_valid, merged_distance, run_last
// cfg      | cfg_we                | cfg_index, cfg_data
//
// the load beat that fills both lists to k starts the merge
// the merge alternates a registered read of both list heads with a compare and pick;
// a held out beat stalls the pick, and the next read waits until the pick is sent
// in_stall is high while the merge runs; a pending out beat does not block loads
// synchronous active-high reset clears fill counts, merge control and config
module topk_sorted_list_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                req_type,
  input  logic [tksm_pkg::IdW-1:0]            entry_id,
  input  logic                                entry_valid,
  input  logic signed [tksm_pkg::DistW-1:0]   entry_distance,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tksm_pkg::IdW-1:0]            merged_id,
  output logic                                merged_valid,
  output logic signed [tksm_pkg::DistW-1:0]   merged_distance,
  output logic                                run_last,
  input  logic                                cfg_we,
  input  logic [tksm_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [tksm_pkg::CfgW-1:0]           cfg_data
);

  logic [tksm_pkg::CfgW-1:0] list_length;
  logic descending_order;
  logic [tksm_pkg::CntW-1:0] k;

  logic [tksm_pkg::CntW-1:0] left_count;
  logic [tksm_pkg::CntW-1:0] right_count;
  logic [tksm_pkg::CntW-1:0] left_count_next;
  logic [tksm_pkg::CntW-1:0] right_count_next;

  logic in_acc;
  logic left_we;
  logic right_we;
  logic busy;
  tksm_pkg::entry_t wentry;
  tksm_pkg::merge_cmd_t cmd;

  logic [tksm_pkg::EntryW-1:0] left_rdata;
  logic [tksm_pkg::EntryW-1:0] right_rdata;
  logic [tksm_pkg::AddrW-1:0] left_raddr;
  logic [tksm_pkg::AddrW-1:0] right_raddr;

  assign k = tksm_pkg::active_len(list_length);
  assign in_stall = busy;
  assign in_acc = in_valid && !in_stall;

  // a load into a full list is dropped
  assign left_we = in_acc && (req_type == tksm_pkg::REQ_LEFT) && (left_count < k);
  assign right_we = in_acc && (req_type == tksm_pkg::REQ_RIGHT) && (right_count < k);

  assign left_count_next = left_we ? left_count + tksm_pkg::CntW'(1) : left_count;
  assign right_count_next = right_we ? right_count + tksm_pkg::CntW'(1) : right_count;

  always_comb begin
    wentry.id = entry_id;
    wentry.valid = entry_valid;
    wentry.distance = entry_distance;
    cmd.start = in_acc && (left_count_next >= k) && (right_count_next >= k);
    cmd.desc = descending_order;
    cmd.k = k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_length <= tksm_pkg::CfgW'(1);
      descending_order <= 1'b0;
      left_count <= '0;
      right_count <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tksm_pkg::CFG_LIST_LENGTH: list_length <= cfg_data;
          tksm_pkg::CFG_DESCENDING: descending_order <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        left_count <= '0;
        right_count <= '0;
      end else begin
        left_count <= left_count_next;
        right_count <= right_count_next;
      end
    end
  end

  tksm_ram #(
    .WIDTH(tksm_pkg::EntryW),
    .DEPTH(tksm_pkg::MaxListLength)
  ) u_left_ram (
    .clk(clk),
    .we(left_we),
    .waddr(left_count[tksm_pkg::AddrW-1:0]),
    .wdata(wentry),
    .raddr(left_raddr),
    .rdata(left_rdata)
  );

  tksm_ram #(
    .WIDTH(tksm_pkg::EntryW),
    .DEPTH(tksm_pkg::MaxListLength)
  ) u_right_ram (
    .clk(clk),
    .we(right_we),
    .waddr(right_count[tksm_pkg::AddrW-1:0]),
    .wdata(wentry),
    .raddr(right_raddr),
    .rdata(right_rdata)
  );

  tksm_merge u_merge (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .left_q(tksm_pkg::entry_t'(left_rdata)),
    .right_q(tksm_pkg::entry_t'(right_rdata)),
    .left_raddr(left_raddr),
    .right_raddr(right_raddr),
    .busy(busy),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .merged_id(merged_id),
    .merged_valid(merged_valid),
    .merged_distance(merged_distance),
    .run_last(run_last)
  );

endmodule

FILE: sim/topk_merge_monitor.sv
module topk_merge_monitor
  import tksm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     req_type,
  input  logic [IdW-1:0]           entry_id,
  input  logic                     entry_valid,
  input  logic signed [DistW-1:0]  entry_distance,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [IdW-1:0]           merged_id,
  input  logic                     merged_valid,
  input  logic signed [DistW-1:0]  merged_distance,
  input  logic                     run_last,
  input  logic                     cfg_we,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [CfgW-1:0]          cfg_data,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IdW-1:0]          id;
    logic                    valid;
    logic signed [DistW-1:0] distance;
    logic                    last;
  } merged_beat_t;

  entry_t left_cands [MaxListLength];
  entry_t right_cands [MaxListLength];
  int left_fill;
  int right_fill;
  logic [CfgW-1:0] len_reg;
  logic desc_reg;
  merged_beat_t merged_due[$];
  merged_beat_t want;
  int errors = 0;

  function automatic void check_field(input string what, input logic [63:0] exp_val,
                                      input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_val, act_val);
      errors++;
    end
  endfunction

  // store one load beat; once both lists hold k entries, walk them into k merged beats
  task automatic load_and_merge(input logic side, input entry_t e);
    int k;
    int li;
    int ri;
    int pos;
    logic pick_left;
    merged_beat_t b;
    k = (len_reg == '0) ? 1 :
        ((int'(len_reg) > MaxListLength) ? MaxListLength : int'(len_reg));
    if (side == REQ_LEFT) begin
      if (left_fill < k) begin
        left_cands[left_fill] = e;
        left_fill++;
      end
    end else if (right_fill < k) begin
      right_cands[right_fill] = e;
      right_fill++;
    end
    if (left_fill >= k && right_fill >= k) begin
      li = 0;
      ri = 0;
      for (pos = 0; pos < k; pos++) begin
        if (!left_cands[li].valid) begin
          pick_left = 1'b0;
        end else if (!right_cands[ri].valid) begin
          pick_left = 1'b1;
        end else if (desc_reg) begin
          pick_left = ($signed(left_cands[li].distance) >=
                       $signed(right_cands[ri].distance));
        end else begin
          pick_left = ($signed(left_cands[li].distance) <=
                       $signed(right_cands[ri].distance));
        end
        if (pick_left) begin
          b.id = left_cands[li].id;
          b.valid = left_cands[li].valid;
          b.distance = left_cands[li].distance;
          li++;
        end else begin
          b.id = right_cands[ri].id;
          b.valid = right_cands[ri].valid;
          b.distance = right_cands[ri].distance;
          ri++;
        end
        b.last = (pos == k - 1);
        merged_due.push_back(b);
      end
      left_fill = 0;
      right_fill = 0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      left_fill = 0;
      right_fill = 0;
      len_reg = CfgW'(1);
      desc_reg = 1'b0;
      merged_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LIST_LENGTH: len_reg = cfg_data;
          CFG_DESCENDING: desc_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (merged_due.size() == 0) begin
          $display("%0t: merged beat with nothing predicted, expected none, actual id %h",
                   $time, merged_id);
          errors++;
        end else begin
          want = merged_due.pop_front();
          check_field("merged_id", 64'(want.id), 64'(merged_id));
          check_field("merged_valid", 64'(want.valid), 64'(merged_valid));
          check_field("merged_distance", 64'($unsigned(want.distance)),
                      64'($unsigned(merged_distance)));
          check_field("run_last", 64'(want.last), 64'(run_last));
        end
      end
      if (in_valid && !in_stall) begin
        load_and_merge(req_type,
                       '{id: entry_id, valid: entry_valid, distance: entry_distance});
      end
    end
    // published after the edge so readers see a settled count
    pending <= merged_due.size();
    fail_count <= errors;
  end

endmodule

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tksm_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 400;
  localparam int RandLoads = 30;
  localparam longint DistMax = 64'sd2147483647;
  localparam longint DistMin = -64'sd2147483648;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic req_type;
  logic [IdW-1:0] entry_id;
  logic entry_valid;
  logic signed [DistW-1:0] entry_distance;
  logic out_valid;
  logic out_stall;
  logic [IdW-1:0] merged_id;
  logic merged_valid;
  logic signed [DistW-1:0] merged_distance;
  logic run_last;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_data;
  int fail_count;
  int pending;

  bit hold_req = 1'b0;
  int burst_left = 0;

  topk_sorted_list_merge dut (.*);

  topk_merge_monitor mon (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // offer one load beat and hold it until taken; gaps fall between bursts
  task automatic send_load(input logic side, input logic [IdW-1:0] id, input logic v,
                           input logic signed [DistW-1:0] dist_val);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    req_type <= side;
    entry_id <= id;
    entry_valid <= v;
    entry_distance <= dist_val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // wait for every predicted beat, then idle the clock for loads still in flight
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // with tidy set the list runs sorted from base in the preferred direction, invalid slots at the tail, else random
  task automatic make_list(ref entry_t lst[$], input int k, input logic desc, input bit tidy,
                           ref longint base, input bit reuse);
    longint d;
    longint incr;
    int n_valid;
    int i;
    entry_t e;
    lst.delete();
    if (!reuse) begin
      case ($urandom_range(0, 3))
        0: base = desc ? DistMax : DistMin;
        1: base = desc ? DistMin + 20 : DistMax - 20;
        default: base = longint'(int'($urandom()));
      endcase
    end
    d = base;
    n_valid = ($urandom_range(0, 3) == 0) ? $urandom_range(0, k) : k;
    for (i = 0; i < k; i++) begin
      e.id = {16'($urandom()), $urandom()};
      if (tidy) begin
        e.valid = (i < n_valid);
        e.distance = d[DistW-1:0];
        incr = ($urandom_range(0, 3) == 0) ? 0 :
               longint'($urandom_range(0, 1 << $urandom_range(0, 28)));
        d = desc ? d - incr : d + incr;
        if (d > DistMax) d = DistMax;
        if (d < DistMin) d = DistMin;
      end else begin
        e.valid = $urandom_range(0, 1);
        e.distance = $urandom();
      end
      lst.push_back(e);
    end
  endtask

  task automatic run_query(input int k, input logic desc);
    entry_t lefts[$];
    entry_t rights[$];
    entry_t e;
    bit tidy;
    longint base;
    tidy = ($urandom_range(0, 4) != 0);
    make_list(lefts, k, desc, tidy, base, 1'b0);
    make_list(rights, k, desc, tidy, base, $urandom_range(0, 3) == 0);
    while (lefts.size() != 0 || rights.size() != 0) begin
      if (rights.size() == 0 || (lefts.size() != 0 && $urandom_range(0, 1) == 1)) begin
        e = lefts.pop_front();
        send_load(REQ_LEFT, e.id, e.valid, e.distance);
        // left list already full here, so this beat is dropped
        if (!tidy && lefts.size() == 0 && rights.size() != 0 && $urandom_range(0, 2) == 0)
          send_load(REQ_LEFT, {16'($urandom()), $urandom()}, 1'b1, $urandom());
      end else begin
        e = rights.pop_front();
        send_load(REQ_RIGHT, e.id, e.valid, e.distance);
        if (!tidy && rights.size() == 0 && lefts.size() != 0 && $urandom_range(0, 2) == 0)
          send_load(REQ_RIGHT, {16'($urandom()), $urandom()}, 1'b0, $urandom());
      end
    end
  endtask

  initial begin
    int mode_sel;
    int span;
    bit hit;
    out_stall <= 1'b0;
    forever begin
      mode_sel = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      repeat (span) begin
        @(posedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          out_stall <= 1'b1;
          repeat (HoldCycles) @(posedge clk);
        end
        case (stall_mode_t'(mode_sel))
          STALL_NONE: hit = 1'b0;
          STALL_HALF: hit = $urandom_range(0, 1);
          STALL_LIGHT: hit = ($urandom_range(0, 3) == 0);
          default: hit = ($urandom_range(0, 4) != 0);
        endcase
        out_stall <= hit;
      end
    end
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    entry_t lefts[$];
    entry_t rights[$];
    entry_t e;
    longint base;
    int rand_loads;
    int qlen;
    int nq;
    int phase;
    logic [CfgW-1:0] len_val;
    logic desc;
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= REQ_LEFT;
    entry_id <= '0;
    entry_valid <= 1'b0;
    entry_distance <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_LIST_LENGTH;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // k = 1 out of reset, ascending
    send_load(REQ_LEFT, 48'hFFFF_FFFF_FFFF, 1'b1, 32'sh7FFF_FFFF);
    send_load(REQ_RIGHT, 48'h0, 1'b1, 32'sh8000_0000);
    // invalid left loses even with the better distance
    send_load(REQ_LEFT, 48'h5555_5555_5555, 1'b0, 32'sh8000_0000);
    send_load(REQ_RIGHT, 48'hAAAA_AAAA_AAAA, 1'b1, 32'sh7FFF_FFFF);
    // both invalid, right head taken
    send_load(REQ_LEFT, 48'h1234_5678_9ABC, 1'b0, 32'sh0000_0010);
    send_load(REQ_RIGHT, 48'hFEDC_BA98_7654, 1'b0, 32'sh0000_0020);
    // invalid right gives the left head
    send_load(REQ_RIGHT, 48'h0000_0000_0001, 1'b0, 32'sh8000_0000);
    send_load(REQ_LEFT, 48'h8000_0000_0000, 1'b1, 32'sh7FFF_FFFF);
    // equal distances go left
    send_load(REQ_RIGHT, 48'h0F0F_0F0F_0F0F, 1'b1, 32'sh0001_0000);
    send_load(REQ_LEFT, 48'hF0F0_F0F0_F0F0, 1'b1, 32'sh0001_0000);
    settle();

    // zero length acts as one; descending
    write_reg(CFG_LIST_LENGTH, '0);
    write_reg(CFG_DESCENDING, CfgW'(1));
    send_load(REQ_LEFT, 48'h0000_0000_0A0A, 1'b1, -32'sd5);
    send_load(REQ_RIGHT, 48'h0000_0000_0B0B, 1'b1, -32'sd5);
    send_load(REQ_LEFT, 48'h0000_0000_0C0C, 1'b1, 32'sd1);
    send_load(REQ_RIGHT, 48'h0000_0000_0D0D, 1'b1, 32'sd2);
    settle();

    // third left beat lands on a full list and is dropped
    write_reg(CFG_LIST_LENGTH, CfgW'(2));
    send_load(REQ_LEFT, 48'h0000_0001_0000, 1'b1, 32'sd900);
    send_load(REQ_LEFT, 48'h0000_0002_0000, 1'b1, 32'sd100);
    send_load(REQ_LEFT, 48'h0000_0003_0000, 1'b1, 32'sd50000);
    send_load(REQ_RIGHT, 48'h0000_0004_0000, 1'b1, 32'sd500);
    send_load(REQ_RIGHT, 48'h0000_0005_0000, 1'b1, -32'sd500);
    settle();

    // length shrinks with both lists part filled; next beat starts the merge
    write_reg(CFG_LIST_LENGTH, CfgW'(3));
    write_reg(CFG_DESCENDING, '0);
    send_load(REQ_LEFT, 48'h0000_0000_0100, 1'b1, -32'sd7);
    send_load(REQ_RIGHT, 48'h0000_0000_0200, 1'b1, -32'sd9);
    send_load(REQ_LEFT, 48'h0000_0000_0300, 1'b1, 32'sd3);
    send_load(REQ_RIGHT, 48'h0000_0000_0400, 1'b1, 32'sd3);
    settle();
    write_reg(CFG_LIST_LENGTH, CfgW'(2));
    send_load(REQ_LEFT, 48'h0000_0000_0500, 1'b1, 32'sd1);
    settle();

    // full-size query, finished after the length is raised past the maximum
    write_reg(CFG_LIST_LENGTH, CfgW'(MaxListLength));
    make_list(lefts, MaxListLength, 1'b0, 1'b1, base, 1'b0);
    make_list(rights, MaxListLength, 1'b0, 1'b1, base, 1'b1);
    while (lefts.size() != 0) begin
      e = lefts.pop_front();
      send_load(REQ_LEFT, e.id, e.valid, e.distance);
    end
    while (rights.size() > 1) begin
      e = rights.pop_front();
      send_load(REQ_RIGHT, e.id, e.valid, e.distance);
    end
    settle();
    write_reg(CFG_LIST_LENGTH, '1);
    e = rights.pop_front();
    send_load(REQ_RIGHT, e.id, e.valid, e.distance);

    rand_loads = 0;
    phase = 0;
    while (rand_loads < RandLoads) begin
      settle();
      case ($urandom_range(0, 9))
        0: len_val = '0;
        1: len_val = CfgW'($urandom_range(9, 24));
        default: len_val = CfgW'($urandom_range(1, 8));
      endcase
      desc = $urandom_range(0, 1);
      write_reg(CFG_LIST_LENGTH, len_val);
      write_reg(CFG_DESCENDING, CfgW'(desc));
      qlen = (len_val == '0) ? 1 : int'(len_val);
      nq = (phase == 0) ? 3 : $urandom_range(1, 4);
      // output side holds off while queries keep coming, so the merge backs up
      if (phase == 0) hold_req = 1'b1;
      repeat (nq) begin
        run_query(qlen, desc);
        rand_loads += 2 * qlen;
      end
      phase++;
    end

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
